[hdl/sws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sws_pkg;
    localparam int Depth = 64;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int LenW = 7;
    localparam int SampleW = 32;
    localparam int SumW = 38;
    localparam int AccW = 48;
    localparam logic [AccW-1:0] AccCap = AccW'(1) << 47;
    localparam logic [30:0] VarMax = 31'h7FFF_FFFF;
    localparam int QShift = 16;
    localparam logic [LenW-1:0] LenReset = LenW'(64);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_WAIT,
        ST_WRITE,
        ST_MM_RD,
        ST_MM_ACC,
        ST_MEAN,
        ST_VAR_RD,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_DIV,
        ST_DELTA,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

[hdl/sws_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface sws_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic signed [31:0] sample;
    modport source (output valid, cmd, sample, input ready);
    modport sink (input valid, cmd, sample, output ready);
endinterface

interface sws_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  fill_level;
    logic signed [37:0] window_sum;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic [30:0] variance_q16;
    logic signed [32:0] step_delta;
    modport source (output valid, fill_level, window_sum, minimum, maximum,
                    variance_q16, step_delta, input ready);
    modport sink (input valid, fill_level, window_sum, minimum, maximum,
                  variance_q16, step_delta, output ready);
endinterface

interface sws_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[hdl/sws_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. Signed handling is left to
// the caller: operands here are magnitudes.
module sws_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [6:0]  i_divisor,
    output logic             o_busy,
    output logic [63:0]      o_quotient
);
    logic [63:0] r_quo, n_quo;
    logic [7:0]  r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_div;
    logic        r_busy, n_busy;
    logic [7:0]  w_trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[6:0], r_quo[63]};
        if (i_start) begin
            n_quo = i_dividend;
            n_rem = '0;
            n_cnt = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_trial - {1'b0, r_div};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

[hdl/sliding_window_statistics.sv]
`timescale 1ns / 1ps
`default_nettype none
// A push evicts the oldest sample when the window is full, writes the new one and walks
// the window for minimum and maximum; with two or more samples it then divides for the mean,
// walks the window again for the variance, divides again and forms the step delta. A clear
// goes straight to the result. One request at a time: a new one is not taken until the memory
// walks and the serial divider are done and the result is taken. Reset empties the window and
// sets the window length to 64; the memory needs no clearing pass.
module sliding_window_statistics (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sws_in_if.sink    in_req,
    sws_out_if.source out_res,
    sws_cfg_if.sink   cfg
);
    import sws_pkg::*;

    // Sample ring: one synchronous memory, registered read data.
    logic [SampleW-1:0] r_mem [Depth];
    logic [SampleW-1:0] r_rd_data;
    logic [AddrW-1:0]   w_rd_addr;
    logic               w_we;
    logic [AddrW-1:0]   w_wr_addr;

    t_state r_state, n_state;

    logic [LenW-1:0]  r_len;
    logic [CntW-1:0]  w_len_eff;
    logic [AddrW-1:0] r_wpos;
    logic [AddrW-1:0] w_wpos_inc;
    logic [CntW-1:0]  r_fill;
    logic signed [SumW-1:0] r_sum;
    logic [SampleW-1:0] r_sample;
    logic [CntW-1:0]  r_idx;
    logic [AddrW-1:0] r_addr;
    logic signed [SampleW-1:0] r_lo, r_hi;
    logic signed [SampleW-1:0] r_newest, r_prev;
    logic signed [SumW-1:0] r_mean;
    logic signed [SumW-1:0] w_x;
    logic signed [SumW-1:0] w_diff;
    logic [SampleW-1:0] r_dev;
    logic [63:0]      w_sq;
    logic [AccW-1:0]  r_acc;
    logic             r_div_phase;
    logic             w_div_start;
    logic [63:0]      w_div_num;
    logic             w_div_busy;
    logic [63:0]      w_div_q;
    logic             r_div_go;
    logic             r_out_valid;
    logic [30:0]      r_var;
    logic signed [32:0] r_delta;
    logic [AddrW-1:0] w_start;
    logic [SumW-1:0]  w_abs_sum;

    // Window length as used: 0 acts as 1, above Depth acts as Depth.
    always_comb begin
        if (r_len == '0) begin
            w_len_eff = CntW'(1);
        end else if (CntW'(r_len) > CntW'(Depth)) begin
            w_len_eff = CntW'(Depth);
        end else begin
            w_len_eff = CntW'(r_len);
        end
    end

    assign in_req.ready = (r_state == ST_IDLE) && !r_out_valid && !cfg.valid;
    assign cfg.ready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_start = (r_fill < w_len_eff) ? '0 : r_wpos;
    assign w_abs_sum = r_sum[SumW-1] ? SumW'(-r_sum) : SumW'(r_sum);
    // Write position after the current push, wrapped at the window length.
    assign w_wpos_inc = (CntW'(r_wpos) + CntW'(1) >= w_len_eff) ? '0 : r_wpos + AddrW'(1);

    // Deviation of the sample just read from the mean, and its square. The deviation
    // of two 32-bit values always fits in 32 bits as a magnitude.
    assign w_x = SumW'($signed(r_rd_data));
    assign w_diff = w_x - r_mean;
    assign w_sq = 64'(r_dev) * 64'(r_dev);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_req.valid && in_req.ready) begin
                    n_state = (in_req.cmd == CMD_CLEAR) ? ST_DONE : ST_EVICT_RD;
                end
            end
            ST_EVICT_RD:   n_state = ST_EVICT_WAIT;
            ST_EVICT_WAIT: n_state = ST_WRITE;
            ST_WRITE:      n_state = ST_MM_RD;
            ST_MM_RD:      n_state = ST_MM_ACC;
            ST_MM_ACC: begin
                if (r_idx + CntW'(1) >= r_fill) begin
                    n_state = (r_fill >= CntW'(2)) ? ST_MEAN : ST_DONE;
                end else begin
                    n_state = ST_MM_RD;
                end
            end
            ST_MEAN: begin
                if (!r_div_go && !w_div_busy) begin
                    n_state = ST_VAR_RD;
                end
            end
            ST_VAR_RD:  n_state = ST_VAR_SQ;
            ST_VAR_SQ:  n_state = ST_VAR_ACC;
            ST_VAR_ACC: begin
                n_state = (r_idx + CntW'(1) >= r_fill) ? ST_DIV : ST_VAR_RD;
            end
            ST_DIV: begin
                if (!r_div_go && !w_div_busy) begin
                    n_state = ST_DELTA;
                end
            end
            ST_DELTA: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Memory address and write control.
    always_comb begin
        w_rd_addr = r_addr;
        w_we = (r_state == ST_WRITE);
        w_wr_addr = r_wpos;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= r_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // The divider computes the mean magnitude first, then the variance.
    assign w_div_start = r_div_go;
    assign w_div_num = r_div_phase ? {r_acc, QShift'(0)} : 64'(w_abs_sum);

    sws_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (r_fill),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len <= LenReset;
            r_wpos <= '0;
            r_fill <= '0;
            r_sum <= '0;
            r_out_valid <= 1'b0;
            r_div_go <= 1'b0;
            r_div_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div_go <= 1'b0;
            if (out_res.valid && out_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg.valid && cfg.ready) begin
                r_len <= cfg.data;
                r_wpos <= '0;
                r_fill <= '0;
                r_sum <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_req.valid && in_req.ready) begin
                        r_sample <= in_req.sample;
                        if (CntW'(r_wpos) >= w_len_eff) begin
                            r_wpos <= '0;
                            r_addr <= '0;
                        end else begin
                            r_addr <= r_wpos;
                        end
                        if (in_req.cmd == CMD_CLEAR) begin
                            r_wpos <= '0;
                            r_fill <= '0;
                            r_sum <= '0;
                        end
                    end
                end
                ST_EVICT_RD: ;
                ST_EVICT_WAIT: begin
                    if (r_fill >= w_len_eff) begin
                        r_sum <= r_sum - SumW'($signed(r_rd_data));
                        r_fill <= w_len_eff;
                    end else begin
                        r_fill <= r_fill + CntW'(1);
                    end
                end
                ST_WRITE: begin
                    r_sum <= r_sum + SumW'($signed(r_sample));
                    r_prev <= r_newest;
                    r_newest <= r_sample;
                    r_wpos <= w_wpos_inc;
                    // The walk starts at the oldest sample of the window.
                    r_addr <= (r_fill < w_len_eff) ? '0 : w_wpos_inc;
                    r_idx <= '0;
                    r_lo <= r_sample;
                    r_hi <= r_sample;
                end
                ST_MM_RD: ;
                ST_MM_ACC: begin
                    r_idx <= r_idx + CntW'(1);
                    if (CntW'(r_addr) + CntW'(1) >= w_len_eff) begin
                        r_addr <= '0;
                    end else begin
                        r_addr <= r_addr + AddrW'(1);
                    end
                    if (r_fill >= CntW'(2) && r_idx + CntW'(1) >= r_fill) begin
                        r_div_go <= 1'b1;
                        r_div_phase <= 1'b0;
                    end
                end
                ST_MEAN: begin
                    if (!r_div_go && !w_div_busy) begin
                        r_mean <= r_sum[SumW-1] ? -SumW'(w_div_q) : SumW'(w_div_q);
                        r_idx <= '0;
                        r_addr <= w_start;
                        r_acc <= '0;
                    end
                end
                ST_VAR_RD: ;
                ST_VAR_SQ: begin
                    r_dev <= w_diff[SumW-1] ? SampleW'(-w_diff) : SampleW'(w_diff);
                end
                ST_VAR_ACC: begin
                    r_idx <= r_idx + CntW'(1);
                    if (CntW'(r_addr) + CntW'(1) >= w_len_eff) begin
                        r_addr <= '0;
                    end else begin
                        r_addr <= r_addr + AddrW'(1);
                    end
                    if (w_sq >= 64'(AccCap - r_acc)) begin
                        r_acc <= AccCap;
                    end else begin
                        r_acc <= r_acc + w_sq[AccW-1:0];
                    end
                    if (r_idx + CntW'(1) >= r_fill) begin
                        r_div_go <= 1'b1;
                        r_div_phase <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (!r_div_go && !w_div_busy) begin
                        r_var <= (w_div_q > 64'(VarMax)) ? VarMax : w_div_q[30:0];
                    end
                end
                ST_DELTA: begin
                    r_delta <= 33'(r_newest) - 33'(r_prev);
                end
                ST_DONE: begin
                    r_out_valid <= 1'b1;
                    if (r_fill < CntW'(2)) begin
                        r_var <= '0;
                        r_delta <= '0;
                    end
                    if (r_fill == '0) begin
                        r_lo <= '0;
                        r_hi <= '0;
                    end
                end
                default: ;
            endcase
            if (r_state == ST_MM_ACC) begin
                if ($signed(r_rd_data) < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if ($signed(r_rd_data) > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end
    end

    assign out_res.valid = r_out_valid;
    assign out_res.fill_level = 7'(r_fill);
    assign out_res.window_sum = r_sum;
    assign out_res.minimum = r_lo;
    assign out_res.maximum = r_hi;
    assign out_res.variance_q16 = r_var;
    assign out_res.step_delta = r_delta;
endmodule
`default_nettype wire
